// ----- hw/rtl/msc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int PATTERN_MAX_DEF   = 24;
  localparam int POSITION_BITS_DEF = 32;
  localparam int TARGET_W          = 34;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int RESULT_DEPTH      = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_MID  = 3'd1,
    REG_PATTERN_HIGH = 3'd2,
    REG_MUST_MATCH   = 3'd3,
    REG_LENGTH       = 3'd4,
    REG_REF_OFFSET   = 3'd5,
    REG_REF_SIZE     = 3'd6,
    REG_ADDED_OFFSET = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] pattern_high;
    logic [63:0] pattern_mid;
    logic [63:0] pattern_low;
    logic [23:0] must_match_mask;
    logic [4:0]  pattern_length;
    logic [4:0]  reference_offset;
    logic [4:0]  reference_size;
    logic [31:0] added_offset;
  } cfg_t;

  // Per-byte compare outcome handed to the match tracker
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        hit;
    logic        bad;
    logic [31:0] disp;
  } hit_t;

  typedef struct packed {
    logic                found;
    logic [31:0]         start;
    logic [TARGET_W-1:0] target;
    logic                bad;
  } report_t;

endpackage

// ----- hw/rtl/msc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_cfg_regs
// Configuration register file; one write per cycle, no read-back.
// ----------------------------------------------------------------------------
module msc_cfg_regs
  import msc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_high     <= '0;
      cfg.pattern_mid      <= '0;
      cfg.pattern_low      <= '0;
      cfg.must_match_mask  <= '0;
      cfg.pattern_length   <= 5'd1;
      cfg.reference_offset <= '0;
      cfg.reference_size   <= '0;
      cfg.added_offset     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  cfg.pattern_low      <= cfg_data;
        REG_PATTERN_MID:  cfg.pattern_mid      <= cfg_data;
        REG_PATTERN_HIGH: cfg.pattern_high     <= cfg_data;
        REG_MUST_MATCH:   cfg.must_match_mask  <= cfg_data[23:0];
        REG_LENGTH:       cfg.pattern_length   <= cfg_data[4:0];
        REG_REF_OFFSET:   cfg.reference_offset <= cfg_data[4:0];
        REG_REF_SIZE:     cfg.reference_size   <= cfg_data[4:0];
        REG_ADDED_OFFSET: cfg.added_offset     <= cfg_data[31:0];
      endcase
    end
  end

endmodule

// ----- hw/rtl/msc_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_window
// Byte window shift line, position counter and parallel masked compare.
// ----------------------------------------------------------------------------
module msc_window
  import msc_pkg::*;
#(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_fire,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output hit_t                     hit,
  output logic [POSITION_BITS-1:0] hit_start
);

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [7:0]               window [PATTERN_MAX];
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] pos_next;
  logic                     s1_valid;
  logic                     s1_last;
  logic                     s1_test;
  logic [POSITION_BITS-1:0] s1_start;

  logic [4:0]   len;
  logic [191:0] pat;
  logic         match;
  logic         bad;
  logic [31:0]  disp;

  assign pat = {cfg.pattern_high, cfg.pattern_mid, cfg.pattern_low};

  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      len = 5'd1;
    end else if (cfg.pattern_length > 5'(PATTERN_MAX)) begin
      len = 5'(PATTERN_MAX);
    end else begin
      len = cfg.pattern_length;
    end
  end

  assign pos_next = pos + POSITION_BITS'(1);

  // Advance the window and position on every accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      window[0] <= data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        window[k] <= window[k-1];
      end
      s1_last  <= last_byte;
      s1_start <= pos_next - POSITION_BITS'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
      s1_test  <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (in_fire) begin
        s1_test <= (pos != '1) && (pos_next >= POSITION_BITS'(len));
        if (last_byte) begin
          pos <= '0;
        end else if (pos != '1) begin
          pos <= pos_next;
        end
      end
    end
  end

  // Window holds the beat of stage 1 here: oldest matched byte at len-1
  always_comb begin
    logic [4:0] idx;
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx = len - 5'd1 - 5'(i);
      if ((5'(i) < len) && cfg.must_match_mask[i]) begin
        if (window[idx[IW-1:0]] != pat[8*i +: 8]) begin
          match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    logic [4:0] idx;
    bad  = (cfg.reference_size != 5'd0) &&
           ((6'(cfg.reference_offset) + 6'd4) > 6'(len));
    disp = '0;
    for (int j = 0; j < 4; j++) begin
      idx = len - 5'd1 - cfg.reference_offset - 5'(j);
      if ((cfg.reference_size != 5'd0) && !bad) begin
        disp[8*j +: 8] = window[idx[IW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit.valid <= 1'b0;
    end else begin
      hit.valid <= s1_valid;
    end
    hit.last  <= s1_last;
    hit.hit   <= s1_test && match;
    hit.bad   <= bad;
    hit.disp  <= disp;
    hit_start <= s1_start;
  end

endmodule

// ----- hw/rtl/msc_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_track
// First-match capture, target arithmetic with saturation and result queue.
// ----------------------------------------------------------------------------
module msc_track
  import msc_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  hit_t                     hit,
  input  logic [POSITION_BITS-1:0] hit_start,
  input  logic                     in_fire_last,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output report_t                  report
);

  localparam int SW = ((POSITION_BITS > 33) ? POSITION_BITS : 33) + 2;
  localparam int PW = $clog2(RESULT_DEPTH);
  localparam int CW = PW + 1;

  logic                     seen;
  logic [POSITION_BITS-1:0] saved_start;
  logic signed [SW-1:0]     saved_sum;
  logic                     saved_bad;

  logic                     s3_valid;
  logic                     s3_found;
  logic [POSITION_BITS-1:0] s3_start;
  logic signed [SW-1:0]     s3_sum;
  logic                     s3_bad;

  logic                     new_hit;
  logic signed [SW-1:0]     sum_next;
  logic [TARGET_W-1:0]      target;

  report_t                  queue [RESULT_DEPTH];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [CW-1:0]            count;
  logic [CW-1:0]            pending;
  logic                     out_fire;

  assign new_hit = hit.valid && hit.hit && !seen;

  // Fold the added offset in at the match so a saved target keeps its value
  always_comb begin
    sum_next = SW'(hit_start);
    if (cfg.reference_size != 5'd0) begin
      sum_next = sum_next + SW'(cfg.reference_offset) + SW'(cfg.reference_size)
                 + SW'($signed(hit.disp));
    end
    sum_next = sum_next + SW'($signed(cfg.added_offset));
  end

  // Keep the first match; hand the region result on at its last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      seen        <= 1'b0;
      saved_start <= '0;
      saved_sum   <= '0;
      saved_bad   <= 1'b0;
      s3_valid    <= 1'b0;
    end else begin
      s3_valid <= hit.valid && hit.last;
      if (hit.valid && hit.last) begin
        seen        <= 1'b0;
        saved_start <= '0;
        saved_sum   <= '0;
        saved_bad   <= 1'b0;
      end else if (new_hit) begin
        seen        <= 1'b1;
        saved_start <= hit_start;
        saved_sum   <= sum_next;
        saved_bad   <= hit.bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_found <= seen || new_hit;
    s3_start <= new_hit ? hit_start : saved_start;
    s3_sum   <= new_hit ? sum_next : saved_sum;
    s3_bad   <= new_hit ? hit.bad : saved_bad;
  end

  always_comb begin
    if (!s3_found) begin
      target = '0;
    end else if (s3_sum[SW-1:TARGET_W-1] != {(SW-TARGET_W+1){s3_sum[TARGET_W-1]}}) begin
      target = s3_sum[SW-1] ? {1'b1, {(TARGET_W-1){1'b0}}} : {1'b0, {(TARGET_W-1){1'b1}}};
    end else begin
      target = s3_sum[TARGET_W-1:0];
    end
  end

  // Result queue; pending counts every last beat not yet taken downstream
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = (pending == CW'(RESULT_DEPTH));
  assign report    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      queue[wr_ptr] <= '{found:  s3_found,
                         start:  32'(s3_start),
                         target: target,
                         bad:    s3_bad};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= '0;
    end else begin
      if (s3_valid) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count   <= count + CW'(s3_valid) - CW'(out_fire);
      pending <= pending + CW'(in_fire_last) - CW'(out_fire);
    end
  end

endmodule

// ----- hw/rtl/masked_byte_pattern_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_unit
// Scans a byte stream for a masked pattern and reports one result per region.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low (parallel window compare).
// Last byte path: stage 1, hit register, stage 3 and queue count, then out_valid.
// The result queue holds 8 regions; input stalls only when 8 are outstanding.
// Reset: synchronous; clears configuration to defaults (length 1) and scan state.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit
  import msc_pkg::*;
#(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [31:0]                match_start,
  output logic signed [TARGET_W-1:0] target_offset,
  output logic                       reference_bad
);

  cfg_t                     cfg;
  hit_t                     hit;
  logic [POSITION_BITS-1:0] hit_start;
  report_t                  report;
  logic                     in_fire;

  assign in_fire = in_valid && !in_stall;

  msc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msc_window #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .hit       (hit),
    .hit_start (hit_start)
  );

  msc_track #(
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .hit          (hit),
    .hit_start    (hit_start),
    .in_fire_last (in_fire && last_byte),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report       (report)
  );

  assign found         = report.found;
  assign match_start   = report.start;
  assign target_offset = $signed(report.target);
  assign reference_bad = report.bad;

endmodule

// ----- verif/masked_byte_pattern_scanner_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_unit_checker
// Watches the register port and both streams of the scanner, keeps its own
// copy of the registers and the scan window, predicts the report of each
// region and compares every accepted report field by field.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit_checker
  import msc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       found,
  input  logic [31:0]                match_start,
  input  logic signed [TARGET_W-1:0] target_offset,
  input  logic                       reference_bad,
  output int                         fails,
  output int                         open_reports
);

  localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS_DEF) - 64'd1;
  localparam longint TARGET_HI = 64'sd8589934591;
  localparam longint TARGET_LO = -64'sd8589934592;

  logic [63:0] pat_lo, pat_mid, pat_hi;
  logic [23:0] must_mask;
  logic [4:0]  len_reg, ref_off, ref_size;
  logic [31:0] added;

  logic [7:0]      window [PATTERN_MAX_DEF];
  longint unsigned bytes_seen;
  report_t         region_report;
  report_t         reports_due [$];

  initial begin
    fails = 0;
    open_reports = 0;
  end

  function automatic int unsigned active_length();
    if (len_reg == 5'd0) return 1;
    if (len_reg > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
    return len_reg;
  endfunction

  function automatic logic [7:0] pattern_at(int unsigned i);
    logic [191:0] pat_all;
    pat_all = {pat_hi, pat_mid, pat_lo};
    return pat_all[8*i +: 8];
  endfunction

  function automatic logic window_hit(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (must_mask[i] && window[n-1-i] != pattern_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    foreach (window[k]) window[k] = 8'h00;
    bytes_seen = 0;
    region_report = '0;
  endtask

  // Save the first hit: start, resolved target and the bad-reference flag
  task automatic note_match(int unsigned n);
    longint      start_pos;
    longint      tgt;
    logic [31:0] disp;
    logic        bad;
    start_pos = longint'(bytes_seen) - longint'(n);
    tgt = start_pos;
    disp = '0;
    bad = 1'b0;
    if (ref_size != 5'd0) begin
      if (int'(ref_off) + 4 > int'(n)) begin
        bad = 1'b1;
      end else begin
        for (int unsigned j = 0; j < 4; j++) disp[8*j +: 8] = window[n-1-(ref_off+j)];
      end
      tgt = tgt + longint'(ref_off) + longint'(ref_size) + longint'($signed(disp));
    end
    tgt = tgt + longint'($signed(added));
    if (tgt > TARGET_HI) tgt = TARGET_HI;
    if (tgt < TARGET_LO) tgt = TARGET_LO;
    region_report.found  = 1'b1;
    region_report.start  = start_pos[31:0];
    region_report.target = tgt[TARGET_W-1:0];
    region_report.bad    = bad;
  endtask

  task automatic take_byte(logic [7:0] b, logic closes);
    int unsigned n;
    n = active_length();
    for (int k = PATTERN_MAX_DEF - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (bytes_seen < POS_LIMIT) begin
      bytes_seen++;
      if (!region_report.found && bytes_seen >= n && window_hit(n)) note_match(n);
    end
    if (closes) begin
      reports_due.push_back(region_report);
      clear_scan();
    end
  endtask

  task automatic take_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_PATTERN_LOW:  pat_lo = value;
      REG_PATTERN_MID:  pat_mid = value;
      REG_PATTERN_HIGH: pat_hi = value;
      REG_MUST_MATCH:   must_mask = value[23:0];
      REG_LENGTH:       len_reg = value[4:0];
      REG_REF_OFFSET:   ref_off = value[4:0];
      REG_REF_SIZE:     ref_size = value[4:0];
      REG_ADDED_OFFSET: added = value[31:0];
      default: ;
    endcase
  endtask

  task automatic show_diff(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
    end
  endtask

  task automatic check_report();
    report_t want;
    if (reports_due.size() == 0) begin
      fails++;
      $display("%0t: report beat with none expected: found %0b start 0x%0h", $time,
               found, match_start);
    end else begin
      want = reports_due.pop_front();
      show_diff("found", 64'(want.found), 64'(found));
      show_diff("match_start", 64'(want.start), 64'(match_start));
      show_diff("target_offset", 64'(want.target), 64'(target_offset[TARGET_W-1:0]));
      show_diff("reference_bad", 64'(want.bad), 64'(reference_bad));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_lo = '0;
      pat_mid = '0;
      pat_hi = '0;
      must_mask = '0;
      len_reg = 5'd1;
      ref_off = '0;
      ref_size = '0;
      added = '0;
      clear_scan();
      reports_due.delete();
    end else begin
      // byte first, config after: a write lands for the next byte on
      if (in_valid && !in_stall) take_byte(data_byte, last_byte);
      if (out_valid && !out_stall) check_report();
      if (cfg_write) take_config(cfg_reg_t'(cfg_index), cfg_data);
    end
    open_reports = reports_due.size();
  end

endmodule

// ----- verif/masked_byte_pattern_scanner_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_unit_test
// Drives regions of bytes through the scanner under a series of pattern,
// mask, length and reference settings: a directed opening, then regions with
// planted, broken and random content, with bursty input and random output
// stalls. The checker beside the block predicts and compares the reports.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_unit_test;
  import msc_pkg::*;

  typedef enum int {REGION_PLANTED, REGION_BROKEN, REGION_NOISE} region_kind_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  cfg_reg_t                   cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 data_byte = 8'h00;
  logic                       last_byte = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       found;
  logic [31:0]                match_start;
  logic signed [TARGET_W-1:0] target_offset;
  logic                       reference_bad;
  int                         fails;
  int                         open_reports;

  // shadow of the settings, used to plant patterns in the stream
  logic [191:0] pat_all;
  logic [23:0]  must_mask;
  logic [4:0]   len_reg, ref_off, ref_size;
  logic [31:0]  added;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  masked_byte_pattern_scanner_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_start(match_start),
    .target_offset(target_offset), .reference_bad(reference_bad)
  );

  masked_byte_pattern_scanner_unit_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .match_start(match_start),
    .target_offset(target_offset), .reference_bad(reference_bad),
    .fails(fails), .open_reports(open_reports)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("masked_byte_pattern_scanner_unit: mismatch");
    $finish;
  end

  // Receiver: free flow, light stalls, or heavy stalls, in stretches
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic int unsigned used_len();
    if (len_reg == 5'd0) return 1;
    if (len_reg > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
    return len_reg;
  endfunction

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Upper bits of the narrow registers carry junk on purpose
  task automatic load_config();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    set_reg(REG_PATTERN_LOW, pat_all[63:0]);
    set_reg(REG_PATTERN_MID, pat_all[127:64]);
    set_reg(REG_PATTERN_HIGH, pat_all[191:128]);
    set_reg(REG_MUST_MATCH, {junk[63:24], must_mask});
    set_reg(REG_LENGTH, {junk[63:5], len_reg});
    set_reg(REG_REF_OFFSET, {junk[58:0], ref_off});
    set_reg(REG_REF_SIZE, {junk[61:3], ref_size});
    set_reg(REG_ADDED_OFFSET, {junk[31:0], added});
  endtask

  task automatic pick_config();
    int unsigned ulen;
    pat_all = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 7) == 0) pat_all = '1;
    else if ($urandom_range(0, 7) == 0) pat_all = '0;
    case ($urandom_range(0, 4))
      0: must_mask = '1;
      1: must_mask = '0;
      2: must_mask = 24'($urandom) & 24'hFFFFFE;
      default: must_mask = 24'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: len_reg = 5'd0;
      1: len_reg = 5'($urandom_range(25, 31));
      2: len_reg = 5'd24;
      3: len_reg = 5'd1;
      default: len_reg = 5'($urandom_range(2, 12));
    endcase
    ulen = used_len();
    if ($urandom_range(0, 3) == 0) ref_off = 5'($urandom_range(0, 31));
    else ref_off = 5'($urandom_range(0, (ulen > 4) ? ulen - 4 : 0));
    ref_size = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    case ($urandom_range(0, 5))
      0: added = 32'h7FFF_FFFF;
      1: added = 32'h8000_0000;
      2: added = 32'h0;
      default: added = $urandom;
    endcase
  endtask

  // One beat; opens a new burst, after a random gap, when the last one ran out
  task automatic push_byte(logic [7:0] value, logic closes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= value;
    last_byte <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_bytes(logic [7:0] seq [$]);
    foreach (seq[k]) push_byte(seq[k], k == seq.size() - 1);
  endtask

  task automatic send_region(region_kind_t kind, output int count);
    logic [7:0]  region_bytes [$];
    int unsigned ulen, spot;
    ulen = used_len();
    if (kind == REGION_NOISE) begin
      repeat ($urandom_range(1, 20)) region_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) region_bytes.push_back(8'($urandom));
      for (int unsigned i = 0; i < ulen; i++)
        region_bytes.push_back(must_mask[i] ? pat_all[8*i +: 8] : 8'($urandom));
      if (kind == REGION_BROKEN) begin
        spot = region_bytes.size() - ulen + $urandom_range(0, ulen - 1);
        region_bytes[spot] = region_bytes[spot] ^ 8'(1 << $urandom_range(0, 7));
      end
      repeat ($urandom_range(0, 4)) region_bytes.push_back(8'($urandom));
    end
    send_bytes(region_bytes);
    count = region_bytes.size();
  endtask

  // Hold input until every report is back, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_reports != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  initial begin
    logic [7:0] seq [$];
    int         sent;
    int         phase_items;
    int         n;
    int         pick;

    pat_all = '0;
    must_mask = '0;
    len_reg = 5'd1;
    ref_off = '0;
    ref_size = '0;
    added = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: length one, all wildcard, so the first byte hits
    seq = '{8'hFF};
    send_bytes(seq);

    // wildcard first byte, reference resolved, added offset of minus one
    drain();
    pat_all = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0034_5678_FF00};
    must_mask = 24'hFFFFFE;
    len_reg = 5'd6;
    ref_off = 5'd1;
    ref_size = 5'd6;
    added = 32'hFFFF_FFFF;
    load_config();
    seq = '{8'h00, 8'h11, 8'hAA, 8'hFF, 8'h78, 8'h56, 8'h34, 8'h00, 8'hFF};
    send_bytes(seq);

    // region shorter than the pattern
    seq = '{8'hFF, 8'h78};
    send_bytes(seq);

    // displacement runs past the pattern end
    drain();
    ref_off = 5'd4;
    set_reg(REG_REF_OFFSET, 64'(ref_off));
    seq = '{8'h5A, 8'hFF, 8'h78, 8'h56, 8'h34, 8'h00};
    send_bytes(seq);

    // length zero behaves as one
    drain();
    len_reg = 5'd0;
    must_mask = 24'h000001;
    set_reg(REG_LENGTH, 64'(len_reg));
    set_reg(REG_MUST_MATCH, 64'(must_mask));
    seq = '{8'h01, 8'h00};
    send_bytes(seq);

    sent = 0;
    while (sent < 500) begin
      drain();
      pick_config();
      load_config();
      phase_items = 0;
      while (phase_items < 50 && sent < 500) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) send_region(REGION_PLANTED, n);
        else if (pick < 17) send_region(REGION_BROKEN, n);
        else send_region(REGION_NOISE, n);
        phase_items += n;
        sent += n;
      end
    end

    drain();
    if (fails == 0 && open_reports == 0) begin
      $display("masked_byte_pattern_scanner_unit: match");
    end else begin
      $display("masked_byte_pattern_scanner_unit: mismatch");
    end
    $finish;
  end

endmodule
